>>> rtl/cbmv_pkg.sv
// shared types and constants of the column block matrix vector multiply
// no dependencies; imported by every module of the block
package cbmv_pkg;

  localparam int ROWS_MAX = 64;
  localparam int COLS_MAX = 64;
  localparam int IDX_W    = 6;
  localparam int CNT_W    = 7;
  localparam int DATA_W   = 32;
  localparam int MAT_AW   = 2 * IDX_W;
  localparam int VEC_AW   = IDX_W + 1;
  localparam int MAT_DEPTH = ROWS_MAX * COLS_MAX;
  localparam int VEC_DEPTH = 2 * ROWS_MAX;
  localparam int QDEPTH   = 4;
  localparam int QAW      = 2;
  localparam int QCW      = 3;

  localparam logic [CNT_W-1:0] ROWS_LIM = CNT_W'(ROWS_MAX);
  localparam logic [CNT_W-1:0] COLS_LIM = CNT_W'(COLS_MAX);

  // register indexes on the configuration port
  localparam logic [1:0] REG_ROWS   = 2'd0;
  localparam logic [1:0] REG_COLS   = 2'd1;
  localparam logic [1:0] REG_OFFSET = 2'd2;

  // encoding follows the mode field
  typedef enum logic [1:0] {
    OP_MAT = 2'd0,
    OP_VEC = 2'd1,
    OP_MUL = 2'd2,
    OP_NOP = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    op_e               op;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [DATA_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic [CNT_W-1:0] rows;
    logic [CNT_W-1:0] cols;
    logic [IDX_W-1:0] col_offset;
  } cfg_t;

  // travels with each product through the back pipeline
  typedef struct packed {
    logic             vld;
    logic             first;
    logic             lastcol;
    logic             lastrow;
    logic             use_v;
    logic [IDX_W-1:0] row;
  } tag_t;

endpackage

>>> rtl/cbmv_front.sv
// front end: accepts items, classifies the mode and queues the work
// depends on cbmv_pkg
module cbmv_front import cbmv_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic [1:0]        mode_i,
  input  logic [IDX_W-1:0]  row_i,
  input  logic [IDX_W-1:0]  col_i,
  input  logic [DATA_W-1:0] value_i,
  output logic              busy,
  input  logic              pop_i,
  output item_t             item_o,
  output logic              empty_o
);

  item_t            q_mem [QDEPTH];
  logic [QAW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCW-1:0]   count_q, count_d;
  item_t            in_item;
  logic             push;
  logic             pop;

  assign busy    = (count_q == QCW'(QDEPTH));
  assign empty_o = (count_q == '0);
  assign item_o  = q_mem[rd_ptr_q];

  always_comb begin
    in_item.op    = op_e'(mode_i);
    in_item.row   = row_i;
    in_item.col   = col_i;
    in_item.value = value_i;
  end

  // unused mode is dropped here and never reaches the back end
  assign push = start && !busy && (in_item.op != OP_NOP);
  assign pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + QCW'(push) - QCW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= in_item;
    end
  end

endmodule

>>> rtl/cbmv_back.sv
// back end: matrix and vector stores, row by column sequencer and
// multiply-accumulate pipeline; depends on cbmv_pkg
module cbmv_back import cbmv_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cfg_t                     cfg_i,
  input  item_t                    item_i,
  input  logic                     empty_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  output logic [IDX_W-1:0]         out_row_o,
  output logic signed [DATA_W-1:0] out_value_o,
  output logic                     last_o
);

  logic [DATA_W-1:0] mat_mem [MAT_DEPTH];
  logic [DATA_W-1:0] vec_mem [VEC_DEPTH];

  state_e            state_q, state_d;
  logic [IDX_W-1:0]  r_q, c_q;
  logic [CNT_W-1:0]  nr_q, nc_q, nr_cfg, nc_cfg;
  logic [IDX_W-1:0]  ncm1_q, off_q;
  logic [ROWS_MAX-1:0] sel_q, flip_mask;

  tag_t              issue, s1_q, s2_q;
  logic [DATA_W-1:0] mat_rd_q, vec_rd_q, prod_q, acc_q, acc_d;
  logic              res_vld_q, res_last_q;
  logic [IDX_W-1:0]  res_row_q;
  logic [DATA_W-1:0] res_value_q;

  logic [CNT_W-1:0]  vi;
  logic [MAT_AW-1:0] mat_raddr;
  logic [VEC_AW-1:0] vec_raddr, vec_waddr;
  logic [DATA_W-1:0] vec_wdata;
  logic              mat_we, vec_we, start_mul, issue_end;

  assign nr_cfg = (cfg_i.rows > ROWS_LIM) ? ROWS_LIM : cfg_i.rows;
  assign nc_cfg = (cfg_i.cols > COLS_LIM) ? COLS_LIM : cfg_i.cols;

  assign pop_o     = (state_q == ST_IDLE) && !empty_i;
  assign start_mul = pop_o && (item_i.op == OP_MUL) && (nr_cfg != '0);
  assign issue_end = (c_q == ncm1_q) && ({1'b0, r_q} == nr_q - 1'b1);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (start_mul) state_d = ST_RUN;
      ST_RUN:   if (issue_end) state_d = ST_DRAIN;
      ST_DRAIN: if (!s1_q.vld && !s2_q.vld && !res_vld_q) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // row and column counters, limits latched at the start of a compute
  always_ff @(posedge clk_i) begin
    if (start_mul) begin
      r_q    <= '0;
      c_q    <= '0;
      nr_q   <= nr_cfg;
      nc_q   <= nc_cfg;
      // zero columns still walks one column per row, masked off
      ncm1_q <= (nc_cfg == '0) ? '0 : IDX_W'(nc_cfg - 1'b1);
      off_q  <= cfg_i.col_offset;
    end else if (state_q == ST_RUN) begin
      if (c_q == ncm1_q) begin
        c_q <= '0;
        r_q <= r_q + 1'b1;
      end else begin
        c_q <= c_q + 1'b1;
      end
    end
  end

  assign vi = {1'b0, c_q} + {1'b0, off_q};

  always_comb begin
    issue.vld     = (state_q == ST_RUN);
    issue.first   = (c_q == '0);
    issue.lastcol = (c_q == ncm1_q);
    issue.lastrow = ({1'b0, r_q} == nr_q - 1'b1);
    issue.use_v   = ({1'b0, c_q} < nc_q) && (vi < nr_q);
    issue.row     = r_q;
  end

  // each vector entry lives in one of two banks; results go to the other
  // bank so later rows of the same compute still see the old vector
  assign mat_raddr = {r_q, c_q};
  assign vec_raddr = {sel_q[vi[IDX_W-1:0]], vi[IDX_W-1:0]};

  assign mat_we    = pop_o && (item_i.op == OP_MAT);
  assign vec_we    = res_vld_q || (pop_o && (item_i.op == OP_VEC));
  assign vec_waddr = res_vld_q ? {~sel_q[res_row_q], res_row_q}
                               : {sel_q[item_i.row], item_i.row};
  assign vec_wdata = res_vld_q ? res_value_q : item_i.value;

  always_ff @(posedge clk_i) begin
    if (mat_we) begin
      mat_mem[{item_i.row, item_i.col}] <= item_i.value;
    end
    mat_rd_q <= mat_mem[mat_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (vec_we) begin
      vec_mem[vec_waddr] <= vec_wdata;
    end
    vec_rd_q <= vec_mem[vec_raddr];
  end

  always_comb begin
    for (int i = 0; i < ROWS_MAX; i++) begin
      flip_mask[i] = (CNT_W'(i) < nr_q);
    end
  end

  assign acc_d = (s2_q.first ? '0 : acc_q) + (s2_q.use_v ? prod_q : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q      <= '0;
      s2_q      <= '0;
      res_vld_q <= 1'b0;
      sel_q     <= '0;
    end else begin
      s1_q      <= issue;
      s2_q      <= s1_q;
      res_vld_q <= s2_q.vld && s2_q.lastcol;
      if (res_vld_q && res_last_q) begin
        sel_q <= sel_q ^ flip_mask;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mat_rd_q * vec_rd_q;
    if (s2_q.vld) begin
      acc_q <= acc_d;
    end
    if (s2_q.vld && s2_q.lastcol) begin
      res_value_q <= acc_d;
      res_row_q   <= s2_q.row;
      res_last_q  <= s2_q.lastrow;
    end
  end

  assign out_valid_o = res_vld_q;
  assign out_row_o   = res_row_q;
  assign out_value_o = res_value_q;
  assign last_o      = res_vld_q && res_last_q;

endmodule

>>> rtl/column_block_matrix_vector_multiply.sv
// top level: configuration registers, front end queue and back end
// depends on cbmv_pkg, cbmv_front and cbmv_back
//
// usage:
//   items enter on start/mode_i/row_i/col_i/value_i and are taken at a clock
//   edge with start high and busy low. mode 0 stores a matrix entry, mode 1 a
//   vector entry, mode 2 runs a compute, mode 3 is dropped.
//   a queue of four items sits between the front end and the back end; busy
//   is high only while that queue is full.
//   a load leaves the queue and is written to its store in the same cycle, so
//   loads sustain one item per cycle while no compute is running.
//   a compute walks rows x max(cols,1) products, one per cycle through the
//   single multiply-accumulate pipeline, and then drains that pipeline; the
//   next item leaves the queue once the back end is idle again. each row's
//   result passes the store read registers and the product register and is
//   registered once its last column has been accumulated.
//   each result is shown for one cycle with out_valid_o; last_o marks the
//   final row. results cannot be held off by the receiver.
//   rows, cols and col_offset are written through the apb port at byte
//   addresses 0, 4 and 8; pready is always high.
//   reset empties the queue and the pipeline and loads rows = cols = 64 and
//   col_offset = 0; the stores hold no defined value until written.
module column_block_matrix_vector_multiply import cbmv_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [3:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               mode_i,
  input  logic [IDX_W-1:0]         row_i,
  input  logic [IDX_W-1:0]         col_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic                     out_valid_o,
  output logic [IDX_W-1:0]         out_row_o,
  output logic signed [DATA_W-1:0] out_value_o,
  output logic                     last_o
);

  cfg_t       cfg_q;
  item_t      item;
  logic       empty, pop;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rows       <= ROWS_LIM;
      cfg_q.cols       <= COLS_LIM;
      cfg_q.col_offset <= '0;
    end else if (wr_en) begin
      if (reg_idx == REG_ROWS)   cfg_q.rows       <= pwdata[CNT_W-1:0];
      if (reg_idx == REG_COLS)   cfg_q.cols       <= pwdata[CNT_W-1:0];
      if (reg_idx == REG_OFFSET) cfg_q.col_offset <= pwdata[IDX_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_ROWS:   prdata = {{(32-CNT_W){1'b0}}, cfg_q.rows};
      REG_COLS:   prdata = {{(32-CNT_W){1'b0}}, cfg_q.cols};
      REG_OFFSET: prdata = {{(32-IDX_W){1'b0}}, cfg_q.col_offset};
      default:    prdata = '0;
    endcase
  end

  cbmv_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .mode_i  (mode_i),
    .row_i   (row_i),
    .col_i   (col_i),
    .value_i (value_i),
    .busy    (busy),
    .pop_i   (pop),
    .item_o  (item),
    .empty_o (empty)
  );

  cbmv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .item_i      (item),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_row_o   (out_row_o),
    .out_value_o (out_value_o),
    .last_o      (last_o)
  );

endmodule

>>> rtl/cbmv_checker.sv
// port level checks of the column block matrix vector multiply
// depends on cbmv_pkg; bound to the top level at the end of this file
module cbmv_checker import cbmv_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             pready,
  input logic             out_valid_o,
  input logic [IDX_W-1:0] out_row_o,
  input logic             last_o
);

  a_pready_high: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready dropped");

  a_last_with_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> out_valid_o)
    else $error("last without a result");

  // rows of one compute come out in order
  a_row_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o ##1 out_valid_o |-> out_row_o == $past(out_row_o) + 1'b1)
    else $error("result rows out of order");

  // the pipeline drains between computes
  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |=> !out_valid_o)
    else $error("result right after last");

endmodule

bind column_block_matrix_vector_multiply cbmv_checker u_cbmv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .pready      (pready),
  .out_valid_o (out_valid_o),
  .out_row_o   (out_row_o),
  .last_o      (last_o)
);
